// File: design/sled_pkg.sv
// shared types, codes and colour table for the rgb status led sequencer
package sled_pkg;

  localparam int LevelW = 10;
  localparam int TimeW  = 32;

  typedef enum logic [2:0] {
    CMD_UPDATE = 3'd0,
    CMD_FLASH  = 3'd1,
    CMD_BUSY   = 3'd2,
    CMD_IDLE   = 3'd3,
    CMD_READY  = 3'd4,
    CMD_BEGIN  = 3'd5,
    CMD_END    = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    COL_BLANK   = 3'd0,
    COL_GREEN   = 3'd1,
    COL_BLUE    = 3'd2,
    COL_YELLOW  = 3'd3,
    COL_RED     = 3'd4,
    COL_MAGENTA = 3'd5,
    COL_CYAN    = 3'd6,
    COL_WHITE   = 3'd7
  } color_t;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_QUIET = 2'd2;

  localparam logic [1:0] ST_ALL_UP  = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_ALL_DN  = 2'd2;

  localparam logic [1:0] REG_LED_MODE = 2'd0;
  localparam logic [1:0] REG_BLINK    = 2'd1;
  localparam logic [1:0] REG_YELLOW   = 2'd2;

  localparam logic [1:0]  LED_MODE_RST = 2'd1;
  localparam logic [15:0] BLINK_RST    = 16'd500;

  typedef struct packed {
    logic [2:0]       command;
    logic [TimeW-1:0] now_ms;
    logic [2:0]       color;
    logic [TimeW-1:0] duration_ms;
    logic [1:0]       new_status;
    logic             in_quiet_hours;
  } item_t;

  typedef struct packed {
    logic [1:0]  led_mode;
    logic [15:0] blink_period_ms;
    logic        yellow_variant;
  } cfg_t;

  typedef struct packed {
    logic             busy_mode;
    logic [1:0]       shown_status;
    logic             blink_on;
    logic [TimeW-1:0] last_blink_ms;
    logic [2:0]       flash_color_held;
    logic [TimeW-1:0] flash_until_ms;
    logic             system_ready;
  } state_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  function automatic rgb_t color_levels(input logic [2:0] c, input logic yellow_alt);
    rgb_t v;
    v = '0;
    case (color_t'(c))
      COL_GREEN: v.green = 10'd50;
      COL_BLUE:  v.blue  = 10'd50;
      COL_YELLOW: begin
        if (yellow_alt) begin
          v.red   = 10'd500;
          v.green = 10'd30;
        end else begin
          v.red   = 10'd600;
          v.green = 10'd15;
        end
      end
      COL_RED: v.red = 10'd1023;
      COL_MAGENTA: begin
        v.red  = 10'd500;
        v.blue = 10'd30;
      end
      COL_CYAN: begin
        v.green = 10'd100;
        v.blue  = 10'd50;
      end
      COL_WHITE: begin
        v.red   = 10'd500;
        v.green = 10'd200;
        v.blue  = 10'd200;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/rgb_status_led_sequencer.sv
// top level of the rgb status led sequencer: input register, state, result register
//
// channel  | handshake              | word
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_stall    | command, now_ms, color, duration_ms, status, quiet
// out      | out_valid / out_stall  | red, green, blue levels
// cfg      | cfg_valid / cfg_ready  | register index, write data
//
// one word per cycle while in_stall is low: a word is held in the input register, is decided there by
// the compare and add logic against the state, and the colour lands in the result register.
// words that set no colour emit nothing.
// reset is synchronous on rst_n and restores the state and configuration registers.
// in_stall rises only when a colour is waiting and the result register is held by out_stall.
module rgb_status_led_sequencer import sled_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_command,
  input  logic [TimeW-1:0] in_now_ms,
  input  logic [2:0]       in_color,
  input  logic [TimeW-1:0] in_duration_ms,
  input  logic [1:0]       in_new_status,
  input  logic             in_in_quiet_hours,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LevelW-1:0] out_red_level,
  output logic [LevelW-1:0] out_green_level,
  output logic [LevelW-1:0] out_blue_level,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  item_t  s1_item_r;
  state_t st_r;
  state_t st_nxt;
  cfg_t   cfg_r;
  logic   emit;
  rgb_t   rgb;
  rgb_t   out_rgb;
  logic   out_free;
  logic   s1_adv;
  logic   in_take;

  assign cfg_ready    = 1'b1;
  assign s1_adv       = !emit || out_free;
  assign in_stall     = s1_valid_r && !s1_adv;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{command:        in_command,
                     now_ms:         in_now_ms,
                     color:          in_color,
                     duration_ms:    in_duration_ms,
                     new_status:     in_new_status,
                     in_quiet_hours: in_in_quiet_hours};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_mode        <= LED_MODE_RST;
      cfg_r.blink_period_ms <= BLINK_RST;
      cfg_r.yellow_variant  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LED_MODE: cfg_r.led_mode        <= cfg_wdata[1:0];
        REG_BLINK:    cfg_r.blink_period_ms <= cfg_wdata;
        REG_YELLOW:   cfg_r.yellow_variant  <= cfg_wdata[0];
        default:      cfg_r                 <= cfg_r;
      endcase
    end
  end

  sled_eval u_eval (
    .item (s1_item_r),
    .cur  (st_r),
    .cfg  (cfg_r),
    .nxt  (st_nxt),
    .emit (emit),
    .rgb  (rgb)
  );

  sled_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid_r && emit && out_free),
    .rgb       (rgb),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rgb   (out_rgb)
  );

  assign out_red_level   = out_rgb.red;
  assign out_green_level = out_rgb.green;
  assign out_blue_level  = out_rgb.blue;

endmodule

// File: design/sled_eval.sv
// next-state and colour decision for one registered command word
module sled_eval import sled_pkg::*; (
  input  item_t  item,
  input  state_t cur,
  input  cfg_t   cfg,
  output state_t nxt,
  output logic   emit,
  output rgb_t   rgb
);

  logic             enabled;
  logic [TimeW-1:0] flash_left;
  logic             flash_live;
  logic [TimeW-1:0] since_blink;
  logic             blink_due;
  logic [2:0]       pick;

  always_comb begin
    case (cfg.led_mode)
      MODE_OFF:   enabled = 1'b0;
      MODE_QUIET: enabled = ~item.in_quiet_hours;
      default:    enabled = 1'b1;
    endcase
  end

  assign flash_left  = cur.flash_until_ms - item.now_ms;
  assign flash_live  = (cur.flash_until_ms != '0) && (flash_left != '0) && !flash_left[TimeW-1];
  assign since_blink = item.now_ms - cur.last_blink_ms;
  assign blink_due   = since_blink >= {16'd0, cfg.blink_period_ms};

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    pick = COL_BLANK;
    case (cmd_t'(item.command))
      CMD_UPDATE: begin
        if (cur.system_ready && !enabled) begin
          nxt.blink_on = 1'b0;
          emit         = 1'b1;
          pick         = COL_BLANK;
        end else if (flash_live) begin
          emit = 1'b1;
          pick = cur.flash_color_held;
        end else begin
          nxt.flash_until_ms = '0;
          if (!cur.busy_mode) begin
            case (cur.shown_status)
              ST_ALL_UP: begin
                emit = 1'b1;
                pick = COL_GREEN;
              end
              ST_PARTIAL: begin
                emit = 1'b1;
                pick = COL_YELLOW;
              end
              ST_ALL_DN: begin
                emit = 1'b1;
                pick = COL_RED;
              end
              default: emit = 1'b0;
            endcase
          end else if (blink_due) begin
            nxt.last_blink_ms = item.now_ms;
            nxt.blink_on      = ~cur.blink_on;
            emit              = 1'b1;
            pick              = cur.blink_on ? COL_BLANK : COL_BLUE;
          end
        end
      end
      CMD_FLASH: begin
        nxt.flash_color_held = item.color;
        nxt.flash_until_ms   = item.now_ms + item.duration_ms;
      end
      CMD_BUSY: begin
        nxt.busy_mode     = 1'b1;
        nxt.blink_on      = 1'b0;
        nxt.last_blink_ms = '0;
      end
      CMD_IDLE: begin
        nxt.busy_mode = 1'b0;
        nxt.blink_on  = 1'b0;
      end
      CMD_READY: nxt.system_ready = 1'b1;
      CMD_BEGIN: begin
        nxt.busy_mode     = 1'b1;
        nxt.blink_on      = 1'b1;
        nxt.last_blink_ms = '0;
      end
      CMD_END: begin
        nxt.shown_status = item.new_status;
        nxt.busy_mode    = 1'b0;
      end
      default: nxt = cur;
    endcase
  end

  assign rgb = color_levels(pick, cfg.yellow_variant);

endmodule

// File: design/sled_out_reg.sv
// result register holding one colour word until the consumer takes it
module sled_out_reg import sled_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  rgb_t rgb,
  output logic free,
  output logic out_valid,
  input  logic out_stall,
  output rgb_t out_rgb
);

  logic valid_r;
  logic valid_nxt;
  rgb_t rgb_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r <= rgb;
    end
  end

  assign out_valid = valid_r;
  assign out_rgb   = rgb_r;

endmodule
